// ----- sv/lbaa_pkg.sv -----
// ----------------------------------------------------------------------------
// lbaa_pkg
// Status codes, operation codes and the control word that travels with each
// item through the Lorentz boost pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbaa_pkg;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_OP       = 2'd1,
    ST_NOT_TIMELIKE = 2'd2,
    ST_SATURATED    = 2'd3
  } status_t;

  localparam logic [1:0] OP_INTO_REST   = 2'd0;
  localparam logic [1:0] OP_OUT_OF_REST = 2'd1;

  typedef struct packed {
    logic    bwd;
    status_t err;
  } lbaa_ctrl_t;

endpackage

// ----- sv/lbaa_in_if.sv -----
// ----------------------------------------------------------------------------
// lbaa_in_if
// Input channel: operation code, frame vector Q and vector P.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lbaa_in_if #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic signed [DATA_WIDTH-1:0] q_energy;
  logic signed [DATA_WIDTH-1:0] q_px;
  logic signed [DATA_WIDTH-1:0] q_py;
  logic signed [DATA_WIDTH-1:0] q_pz;
  logic signed [DATA_WIDTH-1:0] p_energy;
  logic signed [DATA_WIDTH-1:0] p_px;
  logic signed [DATA_WIDTH-1:0] p_py;
  logic signed [DATA_WIDTH-1:0] p_pz;

  modport source (
    output valid, operation, q_energy, q_px, q_py, q_pz,
           p_energy, p_px, p_py, p_pz,
    input  ready
  );

  modport sink (
    input  valid, operation, q_energy, q_px, q_py, q_pz,
           p_energy, p_px, p_py, p_pz,
    output ready
  );
endinterface

// ----- sv/lbaa_out_if.sv -----
// ----------------------------------------------------------------------------
// lbaa_out_if
// Output channel: boosted four-vector and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lbaa_out_if #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] r_energy;
  logic signed [DATA_WIDTH-1:0] r_px;
  logic signed [DATA_WIDTH-1:0] r_py;
  logic signed [DATA_WIDTH-1:0] r_pz;
  logic [1:0]                   status;

  modport source (
    output valid, r_energy, r_px, r_py, r_pz, status,
    input  ready
  );

  modport sink (
    input  valid, r_energy, r_px, r_py, r_pz, status,
    output ready
  );
endinterface

// ----- sv/lbaa_sqrt.sv -----
// ----------------------------------------------------------------------------
// lbaa_sqrt
// Pipelined integer square root, one result bit per stage, with a sideband
// word that travels alongside each item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbaa_sqrt #(
  parameter int RW = 32,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] radicand,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   out_side
);

  logic            vld_r  [RW];
  logic [2*RW-1:0] rad_r  [RW];
  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [SW-1:0]   side_r [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic            vi;
    logic [2*RW-1:0] radi;
    logic [RW+1:0]   remi;
    logic [RW-1:0]   rooti;
    logic [SW-1:0]   sidei;
    logic [RW+3:0]   rem_sh;
    logic [RW+3:0]   trial;
    logic            ge;

    if (s == 0) begin : g_first
      assign vi    = in_valid;
      assign radi  = radicand;
      assign remi  = '0;
      assign rooti = '0;
      assign sidei = in_side;
    end else begin : g_next
      assign vi    = vld_r[s-1];
      assign radi  = rad_r[s-1];
      assign remi  = rem_r[s-1];
      assign rooti = root_r[s-1];
      assign sidei = side_r[s-1];
    end

    always_comb begin
      rem_sh = {remi, radi[2*RW-1 -: 2]};
      trial  = (RW+4)'({rooti, 2'b01});
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vi;
      end
      if (en) begin
        rad_r[s]  <= {radi[2*RW-3:0], 2'b00};
        rem_r[s]  <= ge ? (RW+2)'(rem_sh - trial) : rem_sh[RW+1:0];
        root_r[s] <= {rooti[RW-2:0], ge};
        side_r[s] <= sidei;
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign root      = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

// ----- sv/lbaa_div.sv -----
// ----------------------------------------------------------------------------
// lbaa_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// sideband word that travels alongside each item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbaa_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] quotient,
  output logic [SW-1:0] out_side
);

  logic          vld_r  [NW];
  logic [NW-1:0] x_r    [NW];
  logic [DW-1:0] rem_r  [NW];
  logic [DW-1:0] d_r    [NW];
  logic [SW-1:0] side_r [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic          vi;
    logic [NW-1:0] xi;
    logic [DW-1:0] remi;
    logic [DW-1:0] di;
    logic [SW-1:0] sidei;
    logic [DW:0]   rem_sh;
    logic          ge;

    if (s == 0) begin : g_first
      assign vi    = in_valid;
      assign xi    = dividend;
      assign remi  = '0;
      assign di    = divisor;
      assign sidei = in_side;
    end else begin : g_next
      assign vi    = vld_r[s-1];
      assign xi    = x_r[s-1];
      assign remi  = rem_r[s-1];
      assign di    = d_r[s-1];
      assign sidei = side_r[s-1];
    end

    always_comb begin
      rem_sh = {remi, xi[NW-1]};
      ge     = rem_sh >= {1'b0, di};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vi;
      end
      if (en) begin
        x_r[s]    <= {xi[NW-2:0], ge};
        rem_r[s]  <= ge ? DW'(rem_sh - {1'b0, di}) : rem_sh[DW-1:0];
        d_r[s]    <= di;
        side_r[s] <= sidei;
      end
    end
  end

  assign out_valid = vld_r[NW-1];
  assign quotient  = x_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule

// ----- sv/lorentz_boost_arbitrary_axis_core.sv -----
// ----------------------------------------------------------------------------
// lorentz_boost_arbitrary_axis_core
// Boosts four-vector P into, or back out of, the rest frame of frame vector Q.
//
// The block takes one item per clock cycle while ready is high and returns
// one result per item, in order. The pipeline holds the bit-per-stage square
// root (W stages for W = DATA_WIDTH), the energy divider (2W+2 stages) and
// the boost-factor divider (2W+4+F stages for F = FRAC_BITS).
// Any result stall freezes the pipeline once the output skid register fills,
// and ready then stays low until the result is taken. Status codes are
// ok, invalid operation, frame not timelike and saturated; on the two error
// codes all four result fields are zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lorentz_boost_arbitrary_axis_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic         clk,
  input logic         rst,
  lbaa_in_if.sink     ingress,
  lbaa_out_if.source  egress
);
  import lbaa_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int CW   = $bits(lbaa_ctrl_t);
  localparam int PW   = 2 * W;
  localparam int MW   = 2 * W + 2;
  localparam int DENW = W + 2;
  localparam int REW  = MW + 1;
  localparam int NUMW = MW + 2;
  localparam int N2W  = NUMW + F;
  localparam int FQW  = N2W + 1;
  localparam int FCW  = W + F + 2;
  localparam int HW   = F + 2;
  localparam int PRW  = FCW + W;
  localparam int RW   = PRW + 1;
  localparam int SQS  = CW + MW + 8 * W;
  localparam int D1S  = CW + 1 + DENW + 7 * W;
  localparam int D2S  = CW + 1 + REW + 6 * W;

  logic en;

  // Input register.
  logic                s1_vld;
  logic [1:0]          s1_op;
  logic signed [W-1:0] s1_q [4];
  logic signed [W-1:0] s1_p [4];

  // Products.
  logic                 s2_vld;
  logic [1:0]           s2_op;
  logic signed [PW-1:0] s2_qq [4];
  logic signed [PW-1:0] s2_pq [4];
  logic signed [W-1:0]  s2_q [4];
  logic signed [W-1:0]  s2_p [4];

  // Squared mass and Minkowski product.
  logic                 s3_vld;
  lbaa_ctrl_t           s3_ctrl;
  logic signed [MW-1:0] s3_m2;
  logic signed [MW-1:0] s3_dot;
  logic signed [W-1:0]  s3_q [4];
  logic signed [W-1:0]  s3_p [4];
  logic [PW-1:0]        s3_rad;
  logic signed [MW-1:0] sp_sum;

  logic                 sq_vld;
  logic [W-1:0]         sq_mass;
  logic [SQS-1:0]       sq_side;
  lbaa_ctrl_t           sq_ctrl;
  logic signed [MW-1:0] sq_dot;
  logic signed [W-1:0]  sq_q [4];
  logic signed [W-1:0]  sq_p [4];
  logic signed [DENW-1:0] sq_den;

  // Denominator and energy divider operands.
  logic                   s4_vld;
  lbaa_ctrl_t             s4_ctrl;
  logic                   s4_dneg;
  logic [MW-1:0]          s4_dmag;
  logic [W-1:0]           s4_mass;
  logic signed [DENW-1:0] s4_den;
  logic signed [W-1:0]    s4_q [4];
  logic signed [W-1:0]    s4_p [4];

  logic                   d1_vld;
  logic [MW-1:0]          d1_quo;
  logic [D1S-1:0]         d1_side;
  lbaa_ctrl_t             d1_ctrl;
  logic                   d1_dneg;
  logic signed [DENW-1:0] d1_den;
  logic signed [W-1:0]    d1_q [4];
  logic signed [W-1:0]    d1_p [4];

  // Energy, numerator, boost-factor divider operands.
  logic                   s5_vld;
  lbaa_ctrl_t             s5_ctrl;
  logic signed [REW-1:0]  s5_re;
  logic signed [DENW-1:0] s5_den;
  logic signed [W-1:0]    s5_q [4];
  logic signed [W-1:0]    s5_p [4];

  logic                   s6_vld;
  lbaa_ctrl_t             s6_ctrl;
  logic signed [REW-1:0]  s6_re;
  logic signed [NUMW-1:0] s6_num;
  logic signed [DENW-1:0] s6_den;
  logic signed [W-1:0]    s6_q [4];
  logic signed [W-1:0]    s6_p [4];

  logic                   s7_vld;
  lbaa_ctrl_t             s7_ctrl;
  logic                   s7_qneg;
  logic [N2W-1:0]         s7_nmag;
  logic [DENW-1:0]        s7_dmag;
  logic signed [REW-1:0]  s7_re;
  logic signed [W-1:0]    s7_q [4];
  logic signed [W-1:0]    s7_p [4];

  logic                   d2_vld;
  logic [N2W-1:0]         d2_quo;
  logic [D2S-1:0]         d2_side;
  lbaa_ctrl_t             d2_ctrl;
  logic                   d2_qneg;
  logic signed [REW-1:0]  d2_re;
  logic signed [W-1:0]    d2_q [4];
  logic signed [W-1:0]    d2_p [4];

  // Boost factor, spatial products, final sums.
  logic                   s8_vld;
  lbaa_ctrl_t             s8_ctrl;
  logic signed [FQW-1:0]  s8_fac;
  logic signed [REW-1:0]  s8_re;
  logic signed [W-1:0]    s8_q [4];
  logic signed [W-1:0]    s8_p [4];

  logic                   s9_vld;
  lbaa_ctrl_t             s9_ctrl;
  logic signed [FCW-1:0]  s9_fac;
  logic signed [REW-1:0]  s9_re;
  logic signed [W-1:0]    s9_q [4];
  logic signed [W-1:0]    s9_p [4];
  logic signed [FQW-1:0]  fac_hi;
  logic signed [FQW-1:0]  fac_lo;

  logic                     s10_vld;
  lbaa_ctrl_t               s10_ctrl;
  logic signed [2*W:0]      s10_plo [4];
  logic signed [HW+W-1:0]   s10_phi [4];
  logic signed [REW-1:0]    s10_re;
  logic signed [W-1:0]      s10_p [4];
  logic signed [HW-1:0]     fac_top;
  logic signed [W:0]        fac_bot;

  logic                   s11_vld;
  lbaa_ctrl_t             s11_ctrl;
  logic signed [PRW-1:0]  s11_sum [4];
  logic signed [REW-1:0]  s11_re;
  logic signed [W-1:0]    s11_p [4];

  logic                   s12_vld;
  lbaa_ctrl_t             s12_ctrl;
  logic signed [PRW-1:0]  s12_t [4];
  logic signed [REW-1:0]  s12_re;
  logic signed [W-1:0]    s12_p [4];
  logic [PRW-1:0]         bias;

  logic                   s13_vld;
  lbaa_ctrl_t             s13_ctrl;
  logic signed [RW-1:0]   s13_r [4];
  logic signed [REW-1:0]  s13_re;

  // Clamp and output staging.
  logic [W-1:0]           pd_r [4];
  status_t                pd_st;
  logic                   pd_sat;
  logic signed [REW-1:0]  re_max;
  logic signed [RW-1:0]   r_max;

  logic                   ov;
  logic [W-1:0]           od_r [4];
  status_t                od_st;
  logic                   sv;
  logic [W-1:0]           sd_r [4];
  status_t                sd_st;

  assign en = !sv;
  assign ingress.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      s3_vld  <= 1'b0;
      s4_vld  <= 1'b0;
      s5_vld  <= 1'b0;
      s6_vld  <= 1'b0;
      s7_vld  <= 1'b0;
      s8_vld  <= 1'b0;
      s9_vld  <= 1'b0;
      s10_vld <= 1'b0;
      s11_vld <= 1'b0;
      s12_vld <= 1'b0;
      s13_vld <= 1'b0;
    end else if (en) begin
      s1_vld  <= ingress.valid;
      s2_vld  <= s1_vld;
      s3_vld  <= s2_vld;
      s4_vld  <= sq_vld;
      s5_vld  <= d1_vld;
      s6_vld  <= s5_vld;
      s7_vld  <= s6_vld;
      s8_vld  <= d2_vld;
      s9_vld  <= s8_vld;
      s10_vld <= s9_vld;
      s11_vld <= s10_vld;
      s12_vld <= s11_vld;
      s13_vld <= s12_vld;
    end
  end

  always_comb begin
    sp_sum = MW'(s2_pq[1]) + MW'(s2_pq[2]) + MW'(s2_pq[3]);
    s3_rad = (s3_m2 > 0) ? s3_m2[PW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op   <= ingress.operation;
      s1_q[0] <= ingress.q_energy;
      s1_q[1] <= ingress.q_px;
      s1_q[2] <= ingress.q_py;
      s1_q[3] <= ingress.q_pz;
      s1_p[0] <= ingress.p_energy;
      s1_p[1] <= ingress.p_px;
      s1_p[2] <= ingress.p_py;
      s1_p[3] <= ingress.p_pz;

      s2_op <= s1_op;
      for (int k = 0; k < 4; k++) begin
        s2_qq[k] <= s1_q[k] * s1_q[k];
        s2_pq[k] <= s1_p[k] * s1_q[k];
        s2_q[k]  <= s1_q[k];
        s2_p[k]  <= s1_p[k];
      end

      s3_ctrl.bwd <= (s2_op == OP_OUT_OF_REST);
      s3_m2  <= MW'(s2_qq[0]) - MW'(s2_qq[1]) - MW'(s2_qq[2]) - MW'(s2_qq[3]);
      s3_dot <= (s2_op == OP_INTO_REST) ? MW'(s2_pq[0]) - sp_sum : MW'(s2_pq[0]) + sp_sum;
      if (s2_op != OP_INTO_REST && s2_op != OP_OUT_OF_REST) begin
        s3_ctrl.err <= ST_BAD_OP;
      end else if ((MW'(s2_qq[0]) - MW'(s2_qq[1]) - MW'(s2_qq[2]) - MW'(s2_qq[3])) <= 0) begin
        s3_ctrl.err <= ST_NOT_TIMELIKE;
      end else begin
        s3_ctrl.err <= ST_OK;
      end
      for (int k = 0; k < 4; k++) begin
        s3_q[k] <= s2_q[k];
        s3_p[k] <= s2_p[k];
      end
    end
  end

  lbaa_sqrt #(.RW(W), .SW(SQS)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_vld),
    .radicand  (s3_rad),
    .in_side   ({s3_ctrl, s3_dot, s3_q[0], s3_q[1], s3_q[2], s3_q[3],
                 s3_p[0], s3_p[1], s3_p[2], s3_p[3]}),
    .out_valid (sq_vld),
    .root      (sq_mass),
    .out_side  (sq_side)
  );

  assign {sq_ctrl, sq_dot, sq_q[0], sq_q[1], sq_q[2], sq_q[3],
          sq_p[0], sq_p[1], sq_p[2], sq_p[3]} = sq_side;
  assign sq_den = DENW'(sq_q[0]) + signed'(DENW'(sq_mass));

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ctrl.bwd <= sq_ctrl.bwd;
      if (sq_ctrl.err == ST_OK && (sq_mass == '0 || sq_den == '0)) begin
        s4_ctrl.err <= ST_NOT_TIMELIKE;
      end else begin
        s4_ctrl.err <= sq_ctrl.err;
      end
      s4_dneg <= sq_dot[MW-1];
      s4_dmag <= sq_dot[MW-1] ? MW'(-sq_dot) : MW'(sq_dot);
      s4_mass <= sq_mass;
      s4_den  <= sq_den;
      for (int k = 0; k < 4; k++) begin
        s4_q[k] <= sq_q[k];
        s4_p[k] <= sq_p[k];
      end
    end
  end

  lbaa_div #(.NW(MW), .DW(W), .SW(D1S)) u_div_energy (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_vld),
    .dividend  (s4_dmag),
    .divisor   (s4_mass),
    .in_side   ({s4_ctrl, s4_dneg, s4_den, s4_q[1], s4_q[2], s4_q[3],
                 s4_p[0], s4_p[1], s4_p[2], s4_p[3]}),
    .out_valid (d1_vld),
    .quotient  (d1_quo),
    .out_side  (d1_side)
  );

  assign {d1_ctrl, d1_dneg, d1_den, d1_q[1], d1_q[2], d1_q[3],
          d1_p[0], d1_p[1], d1_p[2], d1_p[3]} = d1_side;
  assign d1_q[0] = '0;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_ctrl <= d1_ctrl;
      s5_re   <= d1_dneg ? -signed'(REW'(d1_quo)) : signed'(REW'(d1_quo));
      s5_den  <= d1_den;
      for (int k = 0; k < 4; k++) begin
        s5_q[k] <= d1_q[k];
        s5_p[k] <= d1_p[k];
      end

      s6_ctrl <= s5_ctrl;
      s6_re   <= s5_re;
      s6_num  <= NUMW'(s5_re) + NUMW'(s5_p[0]);
      s6_den  <= s5_den;
      for (int k = 0; k < 4; k++) begin
        s6_q[k] <= s5_q[k];
        s6_p[k] <= s5_p[k];
      end

      s7_ctrl <= s6_ctrl;
      s7_qneg <= s6_num[NUMW-1] ^ s6_den[DENW-1];
      s7_nmag <= N2W'(s6_num[NUMW-1] ? NUMW'(-s6_num) : NUMW'(s6_num)) << F;
      s7_dmag <= s6_den[DENW-1] ? DENW'(-s6_den) : DENW'(s6_den);
      s7_re   <= s6_re;
      for (int k = 0; k < 4; k++) begin
        s7_q[k] <= s6_q[k];
        s7_p[k] <= s6_p[k];
      end
    end
  end

  lbaa_div #(.NW(N2W), .DW(DENW), .SW(D2S)) u_div_factor (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s7_vld),
    .dividend  (s7_nmag),
    .divisor   (s7_dmag),
    .in_side   ({s7_ctrl, s7_qneg, s7_re, s7_q[1], s7_q[2], s7_q[3],
                 s7_p[1], s7_p[2], s7_p[3]}),
    .out_valid (d2_vld),
    .quotient  (d2_quo),
    .out_side  (d2_side)
  );

  assign {d2_ctrl, d2_qneg, d2_re, d2_q[1], d2_q[2], d2_q[3],
          d2_p[1], d2_p[2], d2_p[3]} = d2_side;
  assign d2_q[0] = '0;
  assign d2_p[0] = '0;

  // A boost factor beyond this range saturates every nonzero spatial term
  // anyway, so it is clamped before the multiplications.
  always_comb begin
    fac_hi = signed'(FQW'({1'b0, {(FCW-1){1'b1}}}));
    fac_lo = -fac_hi - FQW'(1);
    bias   = (PRW'(1) << F) - PRW'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_ctrl <= d2_ctrl;
      s8_fac  <= (d2_qneg ^ !d2_ctrl.bwd) ? -signed'(FQW'(d2_quo))
                                          : signed'(FQW'(d2_quo));
      s8_re   <= d2_re;
      for (int k = 0; k < 4; k++) begin
        s8_q[k] <= d2_q[k];
        s8_p[k] <= d2_p[k];
      end

      s9_ctrl <= s8_ctrl;
      if (s8_fac > fac_hi) begin
        s9_fac <= fac_hi[FCW-1:0];
      end else if (s8_fac < fac_lo) begin
        s9_fac <= fac_lo[FCW-1:0];
      end else begin
        s9_fac <= s8_fac[FCW-1:0];
      end
      s9_re <= s8_re;
      for (int k = 0; k < 4; k++) begin
        s9_q[k] <= s8_q[k];
        s9_p[k] <= s8_p[k];
      end
    end
  end

  always_comb begin
    fac_top = s9_fac[FCW-1:W];
    fac_bot = signed'({1'b0, s9_fac[W-1:0]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_ctrl <= s9_ctrl;
      s10_re   <= s9_re;
      for (int k = 0; k < 4; k++) begin
        s10_plo[k] <= fac_bot * s9_q[k];
        s10_phi[k] <= fac_top * s9_q[k];
        s10_p[k]   <= s9_p[k];
      end

      s11_ctrl <= s10_ctrl;
      s11_re   <= s10_re;
      for (int k = 0; k < 4; k++) begin
        s11_sum[k] <= (PRW'(s10_phi[k]) <<< W) + PRW'(s10_plo[k]);
        s11_p[k]   <= s10_p[k];
      end

      s12_ctrl <= s11_ctrl;
      s12_re   <= s11_re;
      for (int k = 0; k < 4; k++) begin
        s12_t[k] <= (s11_sum[k][PRW-1] ? s11_sum[k] + signed'(bias) : s11_sum[k]) >>> F;
        s12_p[k] <= s11_p[k];
      end

      s13_ctrl <= s12_ctrl;
      s13_re   <= s12_re;
      for (int k = 1; k < 4; k++) begin
        s13_r[k] <= RW'(s12_t[k]) + RW'(s12_p[k]);
      end
      s13_r[0] <= '0;
    end
  end

  always_comb begin
    re_max = signed'(REW'({1'b0, {(W-1){1'b1}}}));
    r_max  = signed'(RW'({1'b0, {(W-1){1'b1}}}));
    pd_sat = 1'b0;
    if (s13_re > re_max) begin
      pd_r[0] = re_max[W-1:0];
      pd_sat  = 1'b1;
    end else if (s13_re < -re_max - REW'(1)) begin
      pd_r[0] = {1'b1, {(W-1){1'b0}}};
      pd_sat  = 1'b1;
    end else begin
      pd_r[0] = s13_re[W-1:0];
    end
    for (int k = 1; k < 4; k++) begin
      if (s13_r[k] > r_max) begin
        pd_r[k] = r_max[W-1:0];
        pd_sat  = 1'b1;
      end else if (s13_r[k] < -r_max - RW'(1)) begin
        pd_r[k] = {1'b1, {(W-1){1'b0}}};
        pd_sat  = 1'b1;
      end else begin
        pd_r[k] = s13_r[k][W-1:0];
      end
    end
    if (s13_ctrl.err != ST_OK) begin
      pd_st = s13_ctrl.err;
      for (int k = 0; k < 4; k++) begin
        pd_r[k] = '0;
      end
    end else begin
      pd_st = pd_sat ? ST_SATURATED : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (egress.ready || !ov) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end else begin
        ov <= s13_vld;
      end
    end else if (s13_vld && en) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (egress.ready || !ov) begin
      if (sv) begin
        od_r  <= sd_r;
        od_st <= sd_st;
      end else begin
        od_r  <= pd_r;
        od_st <= pd_st;
      end
    end else if (en) begin
      sd_r  <= pd_r;
      sd_st <= pd_st;
    end
  end

  assign egress.valid    = ov;
  assign egress.r_energy = od_r[0];
  assign egress.r_px     = od_r[1];
  assign egress.r_py     = od_r[2];
  assign egress.r_pz     = od_r[3];
  assign egress.status   = od_st;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    sv |-> ov)
    else $error("skid register holds an item while the output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(sv) |-> $past(ov && !egress.ready))
    else $error("skid register filled without an output stall");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    ov && (od_st == ST_BAD_OP || od_st == ST_NOT_TIMELIKE)
      |-> (od_r[0] == '0 && od_r[1] == '0 && od_r[2] == '0 && od_r[3] == '0))
    else $error("error result with nonzero fields");

endmodule
